// ===== rtl/fprj_pkg.sv =====
package fprj_pkg;

  // Register map of the configuration port, one 64-bit slot per register.
  typedef enum logic [2:0] {
    REG_CENTER_U    = 3'd0,
    REG_CENTER_V    = 3'd1,
    REG_AFFINE_C    = 3'd2,
    REG_AFFINE_D    = 3'd3,
    REG_AFFINE_E    = 3'd4,
    REG_COEF_COUNT  = 3'd5,
    REG_COEF_SELECT = 3'd6,
    REG_COEF_VALUE  = 3'd7
  } reg_idx_t;

  // Everything an item carries down the pipeline. Fields are filled in as
  // the stage that computes them is passed.
  typedef struct packed {
    logic [31:0]        mx;
    logic [31:0]        my;
    logic               sx;
    logic               sy;
    logic signed [31:0] z;
    logic               zero;
    logic [31:0]        norm;
    logic [30:0]        ux;
    logic [30:0]        uy;
    logic signed [31:0] ang;
    logic signed [47:0] acc;
    logic               hsat;
  } lane_t;

  // Arctangent of 2^-i in Q2.30, truncated; entries 27 to 30 are rounded up.
  function automatic logic [31:0] atan_entry(input logic [5:0] i);
    logic [31:0] v;
    case (i)
      6'd0:    v = 32'h3243F6A8;
      6'd1:    v = 32'h1DAC6705;
      6'd2:    v = 32'h0FADBAFC;
      6'd3:    v = 32'h07F56EA6;
      6'd4:    v = 32'h03FEAB76;
      6'd5:    v = 32'h01FFD55B;
      6'd6:    v = 32'h00FFFAAA;
      6'd7:    v = 32'h007FFF55;
      6'd8:    v = 32'h003FFFEA;
      6'd9:    v = 32'h001FFFFD;
      6'd10:   v = 32'h000FFFFF;
      6'd11:   v = 32'h0007FFFF;
      6'd12:   v = 32'h0003FFFF;
      6'd13:   v = 32'h0001FFFF;
      6'd14:   v = 32'h0000FFFF;
      6'd15:   v = 32'h00007FFF;
      6'd16:   v = 32'h00003FFF;
      6'd17:   v = 32'h00001FFF;
      6'd18:   v = 32'h00000FFF;
      6'd19:   v = 32'h000007FF;
      6'd20:   v = 32'h000003FF;
      6'd21:   v = 32'h000001FF;
      6'd22:   v = 32'h000000FF;
      6'd23:   v = 32'h0000007F;
      6'd24:   v = 32'h0000003F;
      6'd25:   v = 32'h0000001F;
      6'd26:   v = 32'h0000000F;
      6'd27:   v = 32'h00000008;
      6'd28:   v = 32'h00000004;
      6'd29:   v = 32'h00000002;
      6'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/fprj_sqrt.sv =====
module fprj_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [63:0]     in_s,
  input  fprj_pkg::lane_t in_lane,
  output logic            out_vld,
  output fprj_pkg::lane_t out_lane
);
  import fprj_pkg::*;

  localparam int Steps = 32;

  logic        vld_r  [Steps];
  logic [63:0] s_r    [Steps];
  logic [31:0] root_r [Steps];
  logic [35:0] rem_r  [Steps];
  lane_t       lane_r [Steps];

  // One root bit per stage, digit-by-digit restoring square root.
  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic        vld_in;
    logic [63:0] s_in;
    logic [31:0] root_in;
    logic [35:0] rem_in;
    lane_t       lane_in;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] rem_nxt;
    logic [31:0] root_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign s_in    = in_s;
      assign root_in = '0;
      assign rem_in  = '0;
      assign lane_in = in_lane;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign s_in    = s_r[i-1];
      assign root_in = root_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign lane_in = lane_r[i-1];
    end

    always_comb begin
      rem_sh = {rem_in[33:0], s_in[2*(Steps-1-i) +: 2]};
      trial  = {2'b00, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i]    <= s_in;
        root_r[i] <= root_nxt;
        rem_r[i]  <= rem_nxt;
        lane_r[i] <= lane_in;
      end
    end
  end

  // The root leaves as the radial norm.
  always_comb begin
    out_lane      = lane_r[Steps-1];
    out_lane.norm = root_r[Steps-1];
  end
  assign out_vld = vld_r[Steps-1];

endmodule

// ===== rtl/fprj_div.sv =====
module fprj_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  fprj_pkg::lane_t in_lane,
  output logic            out_vld,
  output fprj_pkg::lane_t out_lane
);
  import fprj_pkg::*;

  localparam int Steps = 31;

  logic        vld_r  [Steps];
  logic [31:0] remx_r [Steps];
  logic [31:0] remy_r [Steps];
  logic [30:0] qx_r   [Steps];
  logic [30:0] qy_r   [Steps];
  lane_t       lane_r [Steps];

  // Both unit components, (m << 30) / norm, one quotient bit per stage.
  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic        vld_in;
    logic [31:0] remx_in;
    logic [31:0] remy_in;
    logic [30:0] qx_in;
    logic [30:0] qy_in;
    logic        bitx;
    logic        bity;
    lane_t       lane_in;
    logic [32:0] shx;
    logic [32:0] shy;
    logic [32:0] dvs;
    logic        gex;
    logic        gey;
    logic [32:0] remx_nxt;
    logic [32:0] remy_nxt;

    if (j == 0) begin : g_first
      assign vld_in  = in_vld;
      assign remx_in = {1'b0, in_lane.mx[31:1]};
      assign remy_in = {1'b0, in_lane.my[31:1]};
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign bitx    = in_lane.mx[0];
      assign bity    = in_lane.my[0];
      assign lane_in = in_lane;
    end else begin : g_next
      assign vld_in  = vld_r[j-1];
      assign remx_in = remx_r[j-1];
      assign remy_in = remy_r[j-1];
      assign qx_in   = qx_r[j-1];
      assign qy_in   = qy_r[j-1];
      assign bitx    = 1'b0;
      assign bity    = 1'b0;
      assign lane_in = lane_r[j-1];
    end

    always_comb begin
      dvs      = {1'b0, lane_in.norm};
      shx      = {remx_in, bitx};
      shy      = {remy_in, bity};
      gex      = (shx >= dvs);
      gey      = (shy >= dvs);
      remx_nxt = gex ? (shx - dvs) : shx;
      remy_nxt = gey ? (shy - dvs) : shy;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[j] <= remx_nxt[31:0];
        remy_r[j] <= remy_nxt[31:0];
        qx_r[j]   <= {qx_in[29:0], gex};
        qy_r[j]   <= {qy_in[29:0], gey};
        lane_r[j] <= lane_in;
      end
    end
  end

  always_comb begin
    out_lane    = lane_r[Steps-1];
    out_lane.ux = qx_r[Steps-1];
    out_lane.uy = qy_r[Steps-1];
  end
  assign out_vld = vld_r[Steps-1];

endmodule

// ===== rtl/fprj_cordic.sv =====
module fprj_cordic #(
  parameter int ATAN_STEPS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  fprj_pkg::lane_t in_lane,
  output logic            out_vld,
  output fprj_pkg::lane_t out_lane
);
  import fprj_pkg::*;

  logic               vld_r  [ATAN_STEPS];
  logic signed [35:0] cx_r   [ATAN_STEPS];
  logic signed [35:0] cy_r   [ATAN_STEPS];
  logic signed [31:0] ang_r  [ATAN_STEPS];
  lane_t              lane_r [ATAN_STEPS];

  // Vectoring rotations from (norm, z) toward the x axis, one per stage.
  for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_step
    logic               vld_in;
    logic signed [35:0] cx_in;
    logic signed [35:0] cy_in;
    logic signed [31:0] ang_in;
    lane_t              lane_in;
    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic signed [31:0] step_ang;
    logic signed [35:0] cx_nxt;
    logic signed [35:0] cy_nxt;
    logic signed [31:0] ang_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign cx_in   = $signed({4'b0000, in_lane.norm});
      assign cy_in   = 36'(in_lane.z);
      assign ang_in  = '0;
      assign lane_in = in_lane;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign cx_in   = cx_r[i-1];
      assign cy_in   = cy_r[i-1];
      assign ang_in  = ang_r[i-1];
      assign lane_in = lane_r[i-1];
    end

    always_comb begin
      dx       = cy_in >>> i;
      dy       = cx_in >>> i;
      step_ang = $signed(atan_entry(6'(i)));
      if (!cy_in[35]) begin
        cx_nxt  = cx_in + dx;
        cy_nxt  = cy_in - dy;
        ang_nxt = ang_in + step_ang;
      end else begin
        cx_nxt  = cx_in - dx;
        cy_nxt  = cy_in + dy;
        ang_nxt = ang_in - step_ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i]   <= cx_nxt;
        cy_r[i]   <= cy_nxt;
        ang_r[i]  <= ang_nxt;
        lane_r[i] <= lane_in;
      end
    end
  end

  always_comb begin
    out_lane     = lane_r[ATAN_STEPS-1];
    out_lane.ang = ang_r[ATAN_STEPS-1];
  end
  assign out_vld = vld_r[ATAN_STEPS-1];

endmodule

// ===== rtl/fprj_horner.sv =====
module fprj_horner #(
  parameter int MAX_COEFFS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic signed [47:0] coef [MAX_COEFFS],
  input  logic [4:0]         coef_count,
  input  logic               in_vld,
  input  fprj_pkg::lane_t    in_lane,
  output logic               out_vld,
  output fprj_pkg::lane_t    out_lane
);
  import fprj_pkg::*;

  localparam logic signed [52:0] AccHi = $signed({6'b000000, {47{1'b1}}});
  localparam logic signed [52:0] AccLo = $signed({6'b111111, 47'b0});

  logic        vld_a_r  [MAX_COEFFS];
  logic [55:0] hi_r     [MAX_COEFFS];
  logic [55:0] lo_r     [MAX_COEFFS];
  logic        neg_r    [MAX_COEFFS];
  lane_t       lane_a_r [MAX_COEFFS];
  logic        vld_b_r  [MAX_COEFFS];
  lane_t       lane_b_r [MAX_COEFFS];

  // Each Horner step takes two stages: partial products of acc * theta,
  // then shift, sign, coefficient add and clamp. Steps run from the highest
  // entry down; entries at or above the count add zero, so the accumulator
  // stays zero until the top coefficient in use.
  for (genvar j = 0; j < MAX_COEFFS; j++) begin : g_step
    localparam int K = MAX_COEFFS - 1 - j;

    logic               vld_in;
    lane_t              lane_in;
    logic signed [47:0] acc_in;
    logic [47:0]        ma;
    logic [31:0]        mb;
    logic [55:0]        hi_nxt;
    logic [55:0]        lo_nxt;
    logic [56:0]        psum;
    logic signed [52:0] val;
    logic signed [52:0] ck;
    logic signed [52:0] sum;
    logic signed [47:0] acc_nxt;
    logic               clip;
    lane_t              lane_b_nxt;

    if (j == 0) begin : g_first
      assign vld_in  = in_vld;
      assign lane_in = in_lane;
      assign acc_in  = '0;
    end else begin : g_next
      assign vld_in  = vld_b_r[j-1];
      assign lane_in = lane_b_r[j-1];
      assign acc_in  = lane_b_r[j-1].acc;
    end

    // Partial products of the magnitudes.
    always_comb begin
      ma     = acc_in[47] ? (~acc_in + 48'd1) : acc_in;
      mb     = lane_in.ang[31] ? (~lane_in.ang + 32'd1) : lane_in.ang;
      hi_nxt = ma[47:24] * mb;
      lo_nxt = ma[23:0] * mb;
    end

    // Recombine, add this step's coefficient and clamp to 48 bits.
    always_comb begin
      psum = {1'b0, hi_r[j]} + {25'b0, lo_r[j][55:24]};
      val  = neg_r[j] ? -$signed({2'b00, psum[56:6]}) : $signed({2'b00, psum[56:6]});
      ck   = ({1'b0, coef_count} > 6'(K)) ? 53'(coef[K]) : '0;
      sum  = val + ck;
      clip = 1'b0;
      if (sum > AccHi) begin
        acc_nxt = AccHi[47:0];
        clip    = 1'b1;
      end else if (sum < AccLo) begin
        acc_nxt = AccLo[47:0];
        clip    = 1'b1;
      end else begin
        acc_nxt = sum[47:0];
      end
      lane_b_nxt      = lane_a_r[j];
      lane_b_nxt.acc  = acc_nxt;
      lane_b_nxt.hsat = lane_a_r[j].hsat | clip;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_a_r[j] <= 1'b0;
        vld_b_r[j] <= 1'b0;
      end else if (en) begin
        vld_a_r[j] <= vld_in;
        vld_b_r[j] <= vld_a_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hi_r[j]     <= hi_nxt;
        lo_r[j]     <= lo_nxt;
        neg_r[j]    <= acc_in[47] ^ lane_in.ang[31];
        lane_a_r[j] <= lane_in;
        lane_b_r[j] <= lane_b_nxt;
      end
    end
  end

  assign out_vld  = vld_b_r[MAX_COEFFS-1];
  assign out_lane = lane_b_r[MAX_COEFFS-1];

endmodule

// ===== rtl/fisheye_ray_to_pixel_projection.sv =====
// Stages from input to result: 2 front stages (squares, then sum), 32 square-root
// stages, 31 divider stages, the CORDIC stages, two stages per Horner step and
// 5 affine and output stages.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Reset (synchronous, rst_n low) empties the pipeline and restores the registers
// and the coefficient table to their reset values.
module fisheye_ray_to_pixel_projection #(
  parameter int MAX_COEFFS = 16,
  parameter int ATAN_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_ray_x,
  input  logic signed [31:0] in_ray_y,
  input  logic signed [31:0] in_ray_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pixel_u,
  output logic signed [31:0] out_pixel_v,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import fprj_pkg::*;

  localparam logic signed [47:0] PixHi = $signed({17'b0, {31{1'b1}}});
  localparam logic signed [47:0] PixLo = $signed({{17{1'b1}}, 31'b0});

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Recombine a split product, drop 36 fraction bits, then apply the sign.
  function automatic logic signed [45:0] term_of(input logic [55:0] hi,
                                                 input logic [55:0] lo,
                                                 input logic        neg);
    logic [56:0] s;
    s = {1'b0, hi} + {25'b0, lo[55:24]};
    return neg ? -$signed({1'b0, s[56:12]}) : $signed({1'b0, s[56:12]});
  endfunction

  // ---------------- configuration registers ----------------
  logic signed [31:0] center_u_r, center_v_r, affine_c_r, affine_d_r, affine_e_r;
  logic [4:0]         coef_count_r;
  logic [3:0]         coef_select_r;
  logic [47:0]        coef_value_r;
  logic signed [47:0] coef_tab_r [MAX_COEFFS];
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // Register writes; a coefficient write lands in the entry picked by select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_u_r    <= '0;
      center_v_r    <= '0;
      affine_c_r    <= 32'sh1000_0000;
      affine_d_r    <= '0;
      affine_e_r    <= '0;
      coef_count_r  <= 5'd1;
      coef_select_r <= '0;
      coef_value_r  <= '0;
      for (int i = 0; i < MAX_COEFFS; i++) begin
        coef_tab_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[5:3]))
        REG_CENTER_U:    center_u_r    <= pwdata[31:0];
        REG_CENTER_V:    center_v_r    <= pwdata[31:0];
        REG_AFFINE_C:    affine_c_r    <= pwdata[31:0];
        REG_AFFINE_D:    affine_d_r    <= pwdata[31:0];
        REG_AFFINE_E:    affine_e_r    <= pwdata[31:0];
        REG_COEF_COUNT:  coef_count_r  <= pwdata[4:0];
        REG_COEF_SELECT: coef_select_r <= pwdata[3:0];
        REG_COEF_VALUE: begin
          coef_value_r <= pwdata[47:0];
          for (int i = 0; i < MAX_COEFFS; i++) begin
            if ({1'b0, coef_select_r} == 5'(i)) begin
              coef_tab_r[i] <= pwdata[47:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx_t'(paddr[5:3]))
      REG_CENTER_U:    prdata = {32'b0, center_u_r};
      REG_CENTER_V:    prdata = {32'b0, center_v_r};
      REG_AFFINE_C:    prdata = {32'b0, affine_c_r};
      REG_AFFINE_D:    prdata = {32'b0, affine_d_r};
      REG_AFFINE_E:    prdata = {32'b0, affine_e_r};
      REG_COEF_COUNT:  prdata = {59'b0, coef_count_r};
      REG_COEF_SELECT: prdata = {60'b0, coef_select_r};
      REG_COEF_VALUE:  prdata = {16'b0, coef_value_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------- pipeline advance ----------------
  logic out_valid_r;
  logic adv;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ---------------- front: squares, then their sum ----------------
  logic        f1_vld_r, f2_vld_r;
  logic [63:0] f1_sqx_r, f1_sqy_r, f2_s_r;
  lane_t       f1_lane_r, f2_lane_r;
  logic [31:0] in_mx, in_my;
  logic [63:0] f1_sqx_nxt, f1_sqy_nxt;
  lane_t       f1_lane_nxt;

  always_comb begin
    in_mx            = mag32(in_ray_x);
    in_my            = mag32(in_ray_y);
    f1_sqx_nxt       = in_mx * in_mx;
    f1_sqy_nxt       = in_my * in_my;
    f1_lane_nxt      = '0;
    f1_lane_nxt.mx   = in_mx;
    f1_lane_nxt.my   = in_my;
    f1_lane_nxt.sx   = in_ray_x[31];
    f1_lane_nxt.sy   = in_ray_y[31];
    f1_lane_nxt.z    = in_ray_z;
    f1_lane_nxt.zero = (in_mx == '0) && (in_my == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= in_valid;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_sqx_r  <= f1_sqx_nxt;
      f1_sqy_r  <= f1_sqy_nxt;
      f1_lane_r <= f1_lane_nxt;
      f2_s_r    <= f1_sqx_r + f1_sqy_r;
      f2_lane_r <= f1_lane_r;
    end
  end

  // ---------------- norm, unit vector, angle, polynomial ----------------
  logic  sq_vld, dv_vld, cd_vld, hn_vld;
  lane_t sq_lane, dv_lane, cd_lane, hn_lane;

  fprj_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (f2_vld_r),
    .in_s     (f2_s_r),
    .in_lane  (f2_lane_r),
    .out_vld  (sq_vld),
    .out_lane (sq_lane)
  );

  fprj_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (sq_vld),
    .in_lane  (sq_lane),
    .out_vld  (dv_vld),
    .out_lane (dv_lane)
  );

  fprj_cordic #(
    .ATAN_STEPS (ATAN_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (dv_vld),
    .in_lane  (dv_lane),
    .out_vld  (cd_vld),
    .out_lane (cd_lane)
  );

  fprj_horner #(
    .MAX_COEFFS (MAX_COEFFS)
  ) u_horner (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .coef       (coef_tab_r),
    .coef_count (coef_count_r),
    .in_vld     (cd_vld),
    .in_lane    (cd_lane),
    .out_vld    (hn_vld),
    .out_lane   (hn_lane)
  );

  // ---------------- radial scaling and affine map ----------------
  logic        g1_vld_r, g2_vld_r, g3_vld_r, g4_vld_r;
  lane_t       g1_lane_r, g2_lane_r, g3_lane_r, g4_lane_r;
  logic [54:0] g1_hiu_r, g1_lou_r, g1_hiv_r, g1_lov_r;
  logic        g1_su_r, g1_sv_r, g2_su_r, g2_sv_r;
  logic [47:0] g2_uu_r, g2_vv_r;
  logic [55:0] g3_uch_r, g3_ucl_r, g3_vdh_r, g3_vdl_r, g3_ueh_r, g3_uel_r;
  logic        g3_nc_r, g3_nd_r, g3_ne_r, g3_nv_r;
  logic [39:0] g3_t1_r;
  logic signed [45:0] g4_tc_r, g4_td_r, g4_te_r, g4_t1_r;

  logic [47:0] rho_m;
  logic        rho_neg;
  logic [54:0] g1_hiu_nxt, g1_lou_nxt, g1_hiv_nxt, g1_lov_nxt;
  logic [55:0] sum_u, sum_v;
  logic [31:0] cm, dm, em;
  logic [55:0] g3_uch_nxt, g3_ucl_nxt, g3_vdh_nxt, g3_vdl_nxt, g3_ueh_nxt, g3_uel_nxt;
  logic signed [45:0] t1_mag;

  // rho = -acc: its magnitude times each unit component, split in halves.
  always_comb begin
    rho_m      = hn_lane.acc[47] ? (~hn_lane.acc + 48'd1) : hn_lane.acc;
    rho_neg    = ~hn_lane.acc[47];
    g1_hiu_nxt = rho_m[47:24] * hn_lane.ux;
    g1_lou_nxt = rho_m[23:0] * hn_lane.ux;
    g1_hiv_nxt = rho_m[47:24] * hn_lane.uy;
    g1_lov_nxt = rho_m[23:0] * hn_lane.uy;
  end

  // uu and vv magnitudes in Q24.24.
  always_comb begin
    sum_u = {1'b0, g1_hiu_r} + {25'b0, g1_lou_r[54:24]};
    sum_v = {1'b0, g1_hiv_r} + {25'b0, g1_lov_r[54:24]};
  end

  // Affine products, again split in halves.
  always_comb begin
    cm         = mag32(affine_c_r);
    dm         = mag32(affine_d_r);
    em         = mag32(affine_e_r);
    g3_uch_nxt = g2_uu_r[47:24] * cm;
    g3_ucl_nxt = g2_uu_r[23:0] * cm;
    g3_vdh_nxt = g2_vv_r[47:24] * dm;
    g3_vdl_nxt = g2_vv_r[23:0] * dm;
    g3_ueh_nxt = g2_uu_r[47:24] * em;
    g3_uel_nxt = g2_uu_r[23:0] * em;
    t1_mag     = $signed({6'b0, g3_t1_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
      g2_vld_r <= 1'b0;
      g3_vld_r <= 1'b0;
      g4_vld_r <= 1'b0;
    end else if (adv) begin
      g1_vld_r <= hn_vld;
      g2_vld_r <= g1_vld_r;
      g3_vld_r <= g2_vld_r;
      g4_vld_r <= g3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_lane_r <= hn_lane;
      g1_hiu_r  <= g1_hiu_nxt;
      g1_lou_r  <= g1_lou_nxt;
      g1_hiv_r  <= g1_hiv_nxt;
      g1_lov_r  <= g1_lov_nxt;
      g1_su_r   <= rho_neg ^ hn_lane.sx;
      g1_sv_r   <= rho_neg ^ hn_lane.sy;

      g2_lane_r <= g1_lane_r;
      g2_uu_r   <= sum_u[53:6];
      g2_vv_r   <= sum_v[53:6];
      g2_su_r   <= g1_su_r;
      g2_sv_r   <= g1_sv_r;

      g3_lane_r <= g2_lane_r;
      g3_uch_r  <= g3_uch_nxt;
      g3_ucl_r  <= g3_ucl_nxt;
      g3_vdh_r  <= g3_vdh_nxt;
      g3_vdl_r  <= g3_vdl_nxt;
      g3_ueh_r  <= g3_ueh_nxt;
      g3_uel_r  <= g3_uel_nxt;
      g3_nc_r   <= g2_su_r ^ affine_c_r[31];
      g3_nd_r   <= g2_sv_r ^ affine_d_r[31];
      g3_ne_r   <= g2_su_r ^ affine_e_r[31];
      g3_nv_r   <= g2_sv_r;
      g3_t1_r   <= g2_vv_r[47:8];

      g4_lane_r <= g3_lane_r;
      g4_tc_r   <= term_of(g3_uch_r, g3_ucl_r, g3_nc_r);
      g4_td_r   <= term_of(g3_vdh_r, g3_vdl_r, g3_nd_r);
      g4_te_r   <= term_of(g3_ueh_r, g3_uel_r, g3_ne_r);
      g4_t1_r   <= g3_nv_r ? -t1_mag : t1_mag;
    end
  end

  // ---------------- center offset, clamp and output register ----------------
  logic signed [31:0] pixel_u_r, pixel_v_r, pu_nxt, pv_nxt;
  logic               out_sat_r, out_zero_r, sat_nxt, clip_u, clip_v;
  logic signed [47:0] pu_sum, pv_sum;

  always_comb begin
    pu_sum = $signed({{2{g4_tc_r[45]}}, g4_tc_r}) + $signed({{2{g4_td_r[45]}}, g4_td_r})
           + $signed({{16{center_u_r[31]}}, center_u_r});
    pv_sum = $signed({{2{g4_te_r[45]}}, g4_te_r}) + $signed({{2{g4_t1_r[45]}}, g4_t1_r})
           + $signed({{16{center_v_r[31]}}, center_v_r});
    clip_u = (pu_sum > PixHi) || (pu_sum < PixLo);
    clip_v = (pv_sum > PixHi) || (pv_sum < PixLo);
    if (pu_sum > PixHi) begin
      pu_nxt = PixHi[31:0];
    end else if (pu_sum < PixLo) begin
      pu_nxt = PixLo[31:0];
    end else begin
      pu_nxt = pu_sum[31:0];
    end
    if (pv_sum > PixHi) begin
      pv_nxt = PixHi[31:0];
    end else if (pv_sum < PixLo) begin
      pv_nxt = PixLo[31:0];
    end else begin
      pv_nxt = pv_sum[31:0];
    end
    sat_nxt = g4_lane_r.hsat | clip_u | clip_v;
    // A ray on the optical axis maps straight to the image center.
    if (g4_lane_r.zero) begin
      pu_nxt  = center_u_r;
      pv_nxt  = center_v_r;
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= g4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_u_r  <= pu_nxt;
      pixel_v_r  <= pv_nxt;
      out_sat_r  <= sat_nxt;
      out_zero_r <= g4_lane_r.zero;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_u   = pixel_u_r;
  assign out_pixel_v   = pixel_v_r;
  assign out_saturated = out_sat_r;

  // ---------------- assertions ----------------
  // An accepted item shows up in the first front stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> f1_vld_r)
    else $error("accepted item did not enter the pipeline");

  // While the pipeline is held, f2, g4 and the output stage neither gain nor drop an item.
  a_hold_stages: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(f2_vld_r) && $stable(g4_vld_r) && $stable(out_valid_r)))
    else $error("pipeline moved while held");

  // An on-axis ray yields the center and never flags saturation.
  a_axis_center: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zero_r) |-> (!out_sat_r && (pixel_u_r == center_u_r)
                                     && (pixel_v_r == center_v_r)))
    else $error("on-axis ray did not map to the center");

  // A coefficient write to entry zero lands in the table.
  a_coef_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (paddr[5:3] == REG_COEF_VALUE) && (coef_select_r == 4'd0))
      |=> (coef_tab_r[0] == $past(pwdata[47:0])))
    else $error("coefficient write lost");

endmodule
